// ===== rtl/b64e_pkg.sv =====
// Types, constants and alphabet lookup shared by the base64 stream encoder.
package b64e_pkg;

	localparam logic FUNC_DATA   = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam int JOB_FIFO_DEPTH = 2;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       char_valid;
		logic       last;
	} out_item_t;

	// one classified input item: up to three characters to send
	typedef struct packed {
		logic [2:0][7:0] chars;
		logic [1:0]      cnt;
		logic            fin;
		logic            empty;
	} job_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front end: accepts words, tracks group state and classifies each into a job.
module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	input  b64e_pkg::in_item_t src_item,
	input  logic              space,
	output logic              accept,
	output b64e_pkg::job_t    job
);
	import b64e_pkg::*;

	logic [5:0]  acc_q;
	logic [2:0]  pending_q;
	logic [1:0]  phase_q;

	logic [2:0]  p;
	logic [3:0]  total;
	logic [3:0]  sh1;
	logic        two;
	logic [13:0] word;
	logic [3:0]  rem;
	logic [5:0]  acc_n;
	logic [2:0]  pf;
	logic [5:0]  flush;

	assign accept = src_valid && space;

	always_comb begin
		p     = (pending_q > 3'd4) ? 3'd0 : pending_q;
		total = {1'b0, p} + 4'd8;
		two   = (total >= 4'd12);
		sh1   = total - 4'd6;
		word  = {acc_q, src_item.data_byte};
		rem   = two ? 4'd0 : sh1;
		acc_n = 6'(word & ((14'd1 << rem) - 14'd1));
		pf    = (pending_q > 3'd5) ? 3'd5 : pending_q;
		flush = 6'(acc_q << (3'd6 - pf));

		job = '0;
		if (src_item.func == FUNC_DATA) begin
			job.chars[0] = sextet_char(6'(word >> sh1));
			job.chars[1] = sextet_char(word[5:0]);
			job.cnt      = two ? 2'd2 : 2'd1;
		end else if (phase_q == 2'd0 || pending_q == 3'd0) begin
			job.cnt   = 2'd1;
			job.fin   = 1'b1;
			job.empty = 1'b1;
		end else begin
			job.chars[0] = sextet_char(flush);
			job.chars[1] = PAD_CHAR;
			job.chars[2] = PAD_CHAR;
			job.cnt      = (phase_q == 2'd1) ? 2'd3 : 2'd2;
			job.fin      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pending_q <= '0;
			phase_q   <= '0;
		end else if (accept) begin
			if (src_item.func == FUNC_DATA) begin
				acc_q     <= acc_n;
				pending_q <= rem[2:0];
				phase_q   <= (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
			end else begin
				acc_q     <= '0;
				pending_q <= '0;
				phase_q   <= '0;
			end
		end
	end

endmodule

// ===== rtl/b64e_fifo.sv =====
// Two-entry job queue between front end and back end.
module b64e_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64e_pkg::job_t push_job,
	input  logic           pop,
	output logic           space,
	output logic           head_valid,
	output b64e_pkg::job_t head_job
);
	import b64e_pkg::*;

	localparam int PTR_W = $clog2(JOB_FIFO_DEPTH);

	job_t             mem_q [JOB_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign space      = (count_q != (PTR_W+1)'(JOB_FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(JOB_FIFO_DEPTH))
		else $error("job queue count out of range");

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: steps through the characters of each job into the output register.
module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  b64e_pkg::job_t      job,
	output logic                pop,
	output logic                dst_valid,
	input  logic                dst_ready,
	output b64e_pkg::out_item_t dst_item
);
	import b64e_pkg::*;

	logic [1:0]  idx_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        load;
	logic        item_last;
	logic [7:0]  sel_char;

	assign load      = job_valid && (!out_valid_q || dst_ready);
	assign item_last = (idx_q == job.cnt - 2'd1);
	assign pop       = load && item_last;
	assign dst_valid = out_valid_q;
	assign dst_item  = out_q;

	always_comb begin
		case (idx_q)
			2'd0:    sel_char = job.chars[0];
			2'd1:    sel_char = job.chars[1];
			2'd2:    sel_char = job.chars[2];
			default: sel_char = job.chars[0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.char_code  <= sel_char;
			out_q.char_valid <= !job.empty;
			out_q.last       <= job.fin && item_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= item_last ? 2'd0 : idx_q + 2'd1;
			end else if (dst_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> idx_q < job.cnt)
		else $error("character index beyond job length");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid |-> idx_q == 2'd0)
		else $error("character index not cleared between jobs");
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && (out_q.last == $past(job.fin)))
		else $error("final character of a job not marked correctly");

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// Base64 stream encoder top level: front end, job queue and back end.
//
// Input channel src_valid/src_ready/src_item: one word per item. func = 0
// carries a raw byte; func = 1 finishes the stream, flushing pending bits
// as one character and appending '=' padding up to a multiple of four.
// A finish with nothing pending gives a single word with char_valid = 0
// and last = 1. Only the final word of a finish carries last.
// Output channel dst_valid/dst_ready/dst_item: one character per word.
// An item is first written into the job queue; once it is at the head
// and the output register is free or being emptied, its first character
// is loaded into the output register. The back end sends one character
// a cycle while the receiver is ready, so a byte gives one or two
// characters (two when it completes a 3-byte group) and a finish one to
// three; the output register is the limit on throughput.
// The front end keeps taking items while the two-entry job queue has room,
// so a stalled receiver only blocks the input once the queue fills.
// Reset (arst_n low) clears the bit accumulator, group position, queue
// and output valid; the encoder then starts a fresh stream.
module base64_stream_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  b64e_pkg::in_item_t  src_item,
	output logic                dst_valid,
	input  logic                dst_ready,
	output b64e_pkg::out_item_t dst_item
);
	import b64e_pkg::*;

	logic space;
	logic accept;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	assign src_ready = space;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_item (src_item),
		.space    (space),
		.accept   (accept),
		.job      (push_job)
	);

	b64e_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_job  (push_job),
		.pop       (pop),
		.space     (space),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(head_valid),
		.job      (head_job),
		.pop      (pop),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_item (dst_item)
	);

endmodule
